// ----- design/kcf_pkg.sv -----
// Shared types and constants of the k-mer clump finder.
`timescale 1ns / 1ps
package kcf_pkg;

  // Fixed field widths.
  localparam int BASE_W    = 2;
  localparam int CNT_W     = 10;
  localparam int OUT_IDX_W = 16;
  localparam int KLEN_W    = 4;
  localparam int WLEN_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_VAL_W = 10;

  // Counts saturate at the top of their range.
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd2;

  // Configuration values after reset.
  localparam logic [KLEN_W-1:0] KMER_LENGTH_RESET   = 4'd4;
  localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RESET = 10'd30;
  localparam logic [CNT_W-1:0]  THRESHOLD_RESET     = 10'd3;

  // Result queue.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // Channel payloads.
  typedef struct packed {
    logic [BASE_W-1:0] base;
  } base_item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] kmer_index;
    logic [CNT_W-1:0]     count_now;
  } clump_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_item_t;

  // One word of the count memory.
  typedef struct packed {
    logic             clumped;
    logic [CNT_W-1:0] count;
  } cnt_word_t;

  // Control of one count memory operation.
  typedef struct packed {
    logic             valid;
    logic             is_inc;
    logic [CNT_W-1:0] thr;
  } cnt_op_t;

  // Result of an increment that found a new clump.
  typedef struct packed {
    logic        valid;
    clump_item_t item;
  } cnt_result_t;

endpackage

// ----- design/kcf_stream_if.sv -----
// Valid/ready channel interface used by all ports of the clump finder.
`timescale 1ns / 1ps
interface kcf_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/kmer_clump_finder_top.sv -----
// Top level of the streaming k-mer clump finder.
//
// Bases enter on the bases channel, one 2-bit code (A=0, C=1, G=2, T=3) per
// transaction. Each newly clumped k-mer leaves on the clumps channel with its
// index and its count in the current window. Configuration registers
// (kmer_length, window_length, threshold) are written on the cfg channel,
// which is always ready; writes take effect for the next base.
//
// A new base is not accepted while the previous one is in s0: each base
// does a decrement and an increment in the count memory, whose single read
// port serves one operation per cycle. A result passes s0 to s2, the count
// unit's operation stage and the output FIFO before it is valid on clumps.
//
// After reset the count memory and the history ring are cleared, one entry
// per cycle, over max(4**MAX_KMER_LENGTH, MAX_WINDOW) addresses (65536 by
// default); bases is not ready during that pass. A new sequence needs reset.
// Results queue in a four-entry FIFO; when the receiver stalls, bases drops
// ready once every free FIFO entry is claimed by a base still in flight.
`timescale 1ns / 1ps
module kmer_clump_finder_top
  import kcf_pkg::*;
#(
  parameter int MAX_KMER_LENGTH = 8,
  parameter int MAX_WINDOW      = 512
) (
  input  logic         clk,
  input  logic         rst,
  kcf_stream_if.sink   cfg,
  kcf_stream_if.sink   bases,
  kcf_stream_if.source clumps
);

  localparam int IDX_W      = 2 * MAX_KMER_LENGTH;
  localparam int TABLE_SIZE = 2 ** IDX_W;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int POS_W      = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W      = (POS_W > WLEN_W) ? POS_W + 1 : WLEN_W + 1;
  localparam int K_CAP      = (MAX_KMER_LENGTH < MAX_WINDOW) ? MAX_KMER_LENGTH : MAX_WINDOW;
  localparam int CLR_LEN    = (TABLE_SIZE > MAX_WINDOW) ? TABLE_SIZE : MAX_WINDOW;
  localparam int CLR_W      = $clog2(CLR_LEN);

  typedef struct packed {
    logic              do_dec;
    logic              do_inc;
    logic [SLOT_W-1:0] leave;
    logic [SLOT_W-1:0] enter;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  thr;
  } stage_t;

  logic [KLEN_W-1:0]     cfg_k;
  logic [WLEN_W-1:0]     cfg_w;
  logic [CNT_W-1:0]      cfg_t;
  logic [KLEN_W-1:0]     k_eff;
  logic [KLEN_W-1:0]     k_m1;
  logic [CMP_W-1:0]      w_wide;
  logic [POS_W-1:0]      w_eff;
  logic [CNT_W-1:0]      t_eff;
  logic [IDX_W-1:0]      kmer_mask;
  logic [IDX_W-1:0]      rolling;
  logic [IDX_W-1:0]      rolling_next;
  logic [POS_W-1:0]      pos;
  logic [SLOT_W-1:0]     ring;
  logic [SLOT_W:0]       leave_sum;
  logic [SLOT_W:0]       enter_sum;
  stage_t                entry;
  logic                  in_acc;
  logic                  s0_valid;
  logic                  s1_valid;
  logic                  s2_valid;
  logic                  s3_valid;
  stage_t                s0;
  stage_t                s1;
  stage_t                s2;
  logic                  clr_busy;
  logic [CLR_W-1:0]      clr_cnt;
  logic                  cnt_clear_we;
  logic                  hist_clear_we;
  logic                  hist_valid;
  logic [IDX_W-1:0]      hist_idx;
  cnt_op_t               op;
  logic [IDX_W-1:0]      op_addr;
  cnt_result_t           result;
  logic [FIFO_CNT_W-1:0] fifo_fill;
  logic [FIFO_CNT_W:0]   credit_used;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_k <= KMER_LENGTH_RESET;
      cfg_w <= WINDOW_LENGTH_RESET;
      cfg_t <= THRESHOLD_RESET;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        CFG_KMER_LENGTH:   cfg_k <= cfg.data.value[KLEN_W-1:0];
        CFG_WINDOW_LENGTH: cfg_w <= cfg.data.value[WLEN_W-1:0];
        CFG_THRESHOLD:     cfg_t <= cfg.data.value[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective k-mer length, window length and threshold.
  always_comb begin
    if (cfg_k == '0) begin
      k_eff = KLEN_W'(1);
    end else if (cfg_k > KLEN_W'(K_CAP)) begin
      k_eff = KLEN_W'(K_CAP);
    end else begin
      k_eff = cfg_k;
    end
    w_wide = CMP_W'(cfg_w);
    if (w_wide < CMP_W'(k_eff)) begin
      w_wide = CMP_W'(k_eff);
    end
    if (w_wide > CMP_W'(MAX_WINDOW)) begin
      w_wide = CMP_W'(MAX_WINDOW);
    end
  end

  assign w_eff = POS_W'(w_wide);
  assign t_eff = (cfg_t == '0) ? CNT_W'(1) : cfg_t;
  assign k_m1  = k_eff - KLEN_W'(1);

  // Rolling k-mer index of the incoming base.
  assign kmer_mask    = ~({IDX_W{1'b1}} << {k_eff, 1'b0});
  assign rolling_next = ((rolling << 2) | IDX_W'(bases.data.base)) & kmer_mask;

  // Ring slots of the leaving and the entering k-mer.
  assign leave_sum = (SLOT_W+1)'(ring) + (SLOT_W+1)'(MAX_WINDOW) - (SLOT_W+1)'(w_eff);
  assign enter_sum = (SLOT_W+1)'(ring) + (SLOT_W+1)'(MAX_WINDOW) - (SLOT_W+1)'(k_m1);

  always_comb begin
    entry.do_dec = (pos >= w_eff);
    entry.do_inc = ((POS_W+1)'(pos) + (POS_W+1)'(1)) >= (POS_W+1)'(k_eff);
    if (leave_sum >= (SLOT_W+1)'(MAX_WINDOW)) begin
      entry.leave = SLOT_W'(leave_sum - (SLOT_W+1)'(MAX_WINDOW));
    end else begin
      entry.leave = SLOT_W'(leave_sum);
    end
    if (enter_sum >= (SLOT_W+1)'(MAX_WINDOW)) begin
      entry.enter = SLOT_W'(enter_sum - (SLOT_W+1)'(MAX_WINDOW));
    end else begin
      entry.enter = SLOT_W'(enter_sum);
    end
    entry.idx = rolling_next;
    entry.thr = t_eff;
  end

  // Input handshake: no new base while one is in s0, only with room for its result.
  assign credit_used = (FIFO_CNT_W+1)'(fifo_fill) + (FIFO_CNT_W+1)'(s1_valid)
                     + (FIFO_CNT_W+1)'(s2_valid) + (FIFO_CNT_W+1)'(s3_valid);
  assign bases.ready = !clr_busy && !s0_valid && (credit_used < (FIFO_CNT_W+1)'(FIFO_DEPTH));
  assign in_acc      = bases.valid && bases.ready;

  // Sequence state and the per-base pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      rolling  <= '0;
      pos      <= '0;
      ring     <= '0;
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        rolling <= rolling_next;
        if (pos != POS_W'(MAX_WINDOW)) begin
          pos <= pos + POS_W'(1);
        end
        if (ring == SLOT_W'(MAX_WINDOW - 1)) begin
          ring <= '0;
        end else begin
          ring <= ring + SLOT_W'(1);
        end
      end
      s0_valid <= in_acc;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    if (in_acc) begin
      s0 <= entry;
    end
    s1 <= s0;
    s2 <= s1;
  end

  // Clearing pass over both memories after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
    end else if (clr_busy) begin
      clr_cnt <= clr_cnt + CLR_W'(1);
      if (clr_cnt == CLR_W'(CLR_LEN - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  assign cnt_clear_we  = clr_busy && ((CLR_W+1)'(clr_cnt) < (CLR_W+1)'(TABLE_SIZE));
  assign hist_clear_we = clr_busy && ((CLR_W+1)'(clr_cnt) < (CLR_W+1)'(MAX_WINDOW));

  // History ring: read and invalidate in stage s0, write in stage s1.
  kcf_history #(
    .DEPTH  (MAX_WINDOW),
    .SLOT_W (SLOT_W),
    .IDX_W  (IDX_W)
  ) u_history (
    .clk        (clk),
    .clear_we   (hist_clear_we),
    .clear_addr (clr_cnt[SLOT_W-1:0]),
    .rd_en      (s0_valid),
    .rd_addr    (s0.leave),
    .inv_en     (s0_valid && s0.do_dec),
    .wr_en      (s1_valid && s1.do_inc),
    .wr_addr    (s1.enter),
    .wr_idx     (s1.idx),
    .rd_valid   (hist_valid),
    .rd_idx     (hist_idx)
  );

  // Count operations: decrement issued from s1, increment from s2.
  always_comb begin
    if (s2_valid) begin
      op.valid  = s2.do_inc;
      op.is_inc = 1'b1;
      op.thr    = s2.thr;
      op_addr   = s2.idx;
    end else begin
      op.valid  = s1_valid && s1.do_dec && hist_valid;
      op.is_inc = 1'b0;
      op.thr    = s1.thr;
      op_addr   = hist_idx;
    end
  end

  kcf_count_unit #(
    .IDX_W (IDX_W)
  ) u_count (
    .clk        (clk),
    .rst        (rst),
    .clear_we   (cnt_clear_we),
    .clear_addr (clr_cnt[IDX_W-1:0]),
    .op         (op),
    .op_addr    (op_addr),
    .result     (result)
  );

  kcf_out_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (result),
    .clumps (clumps),
    .fill   (fifo_fill)
  );

endmodule

// ----- design/kcf_history.sv -----
// Ring memory of recent k-mer indices, each with a valid bit.
`timescale 1ns / 1ps
module kcf_history
  import kcf_pkg::*;
#(
  parameter int DEPTH  = 512,
  parameter int SLOT_W = 9,
  parameter int IDX_W  = 16
) (
  input  logic              clk,
  input  logic              clear_we,
  input  logic [SLOT_W-1:0] clear_addr,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  input  logic              inv_en,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  logic [IDX_W-1:0]  wr_idx,
  output logic              rd_valid,
  output logic [IDX_W-1:0]  rd_idx
);

  // Top bit of each entry is its valid flag.
  logic [IDX_W:0] mem [DEPTH];
  logic [IDX_W:0] rd_word;

  // Read the leaving slot; the same cycle may invalidate it, and the read
  // still returns the old entry. An entering write wins over an invalidate.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
    if (clear_we) begin
      mem[clear_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= {1'b1, wr_idx};
    end else if (inv_en) begin
      mem[rd_addr] <= '0;
    end
  end

  assign rd_valid = rd_word[IDX_W];
  assign rd_idx   = rd_word[IDX_W-1:0];

endmodule

// ----- design/kcf_count_unit.sv -----
// Count and clump-mark memory with a read-modify-write stage and forwarding.
`timescale 1ns / 1ps
module kcf_count_unit
  import kcf_pkg::*;
#(
  parameter int IDX_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear_we,
  input  logic [IDX_W-1:0] clear_addr,
  input  cnt_op_t          op,
  input  logic [IDX_W-1:0] op_addr,
  output cnt_result_t      result
);

  localparam int TABLE_SIZE = 2 ** IDX_W;

  cnt_word_t        mem [TABLE_SIZE];
  cnt_word_t        rd_word;
  cnt_op_t          st_op;
  logic [IDX_W-1:0] st_addr;
  logic             fwd_valid;
  logic [IDX_W-1:0] fwd_addr;
  cnt_word_t        fwd_word;
  cnt_word_t        cur_word;
  cnt_word_t        new_word;
  logic             hit;

  // Memory read port and write port.
  always_ff @(posedge clk) begin
    if (op.valid) begin
      rd_word <= mem[op_addr];
    end
    if (clear_we) begin
      mem[clear_addr] <= '0;
    end else if (st_op.valid) begin
      mem[st_addr] <= new_word;
    end
  end

  // Operation stage and the write of the previous cycle for forwarding.
  always_ff @(posedge clk) begin
    if (rst) begin
      st_op     <= '0;
      fwd_valid <= 1'b0;
    end else begin
      st_op     <= op;
      fwd_valid <= st_op.valid;
    end
    st_addr  <= op_addr;
    fwd_addr <= st_addr;
    fwd_word <= new_word;
  end

  // The read raced with last cycle's write to the same entry: take the
  // written word instead of the memory data.
  assign cur_word = (fwd_valid && (fwd_addr == st_addr)) ? fwd_word : rd_word;

  // Saturating increment with clump check, or decrement floored at zero.
  always_comb begin
    new_word = cur_word;
    hit      = 1'b0;
    if (st_op.is_inc) begin
      if (cur_word.count != CNT_MAX) begin
        new_word.count = cur_word.count + CNT_W'(1);
      end
      hit              = (new_word.count >= st_op.thr) && !cur_word.clumped;
      new_word.clumped = cur_word.clumped | hit;
    end else if (cur_word.count != '0) begin
      new_word.count = cur_word.count - CNT_W'(1);
    end
  end

  assign result.valid           = st_op.valid && st_op.is_inc && hit;
  assign result.item.kmer_index = OUT_IDX_W'(st_addr);
  assign result.item.count_now  = new_word.count;

endmodule

// ----- design/kcf_out_fifo.sv -----
// Small result queue that drives the output channel.
`timescale 1ns / 1ps
module kcf_out_fifo
  import kcf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cnt_result_t           push,
  kcf_stream_if.source          clumps,
  output logic [FIFO_CNT_W-1:0] fill
);

  clump_item_t           mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;

  assign pop          = clumps.valid && clumps.ready;
  assign clumps.valid = (fill != '0);
  assign clumps.data  = mem[rd_ptr];

  // Entry storage; the producer never pushes into a full queue.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      if (push.valid && !pop) begin
        fill <= fill + FIFO_CNT_W'(1);
      end else if (pop && !push.valid) begin
        fill <= fill - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

// ----- design/kcf_checker.sv -----
// Port-level assertions for the clump finder and their bind to the top level.
`timescale 1ns / 1ps
module kcf_checker
  import kcf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input clump_item_t out_data
);

  // Ready drops after each accepted base.
  a_base_spacing: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("base accepted in two consecutive cycles");

  // The clearing pass holds off input right after reset.
  a_reset_holds_input: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input ready right after reset");

  // A clump is reported only with a nonzero count.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.count_now != '0))
    else $error("clump reported with zero count");

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result dropped or changed");

endmodule

bind kmer_clump_finder_top kcf_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (bases.valid),
  .in_ready  (bases.ready),
  .out_valid (clumps.valid),
  .out_ready (clumps.ready),
  .out_data  (clumps.data)
);

// ----- bench/tb_top.sv -----
// Testbench for the k-mer clump finder: directed and random base streams checked by a count model.
`timescale 1ns / 1ps
module tb_top;
  import kcf_pkg::*;

  localparam int MAX_K        = 8;
  localparam int MAX_W        = 512;
  localparam int TABLE_SIZE   = 1 << (2 * MAX_K);
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 12;

  typedef enum logic [1:0] {NT_A, NT_C, NT_G, NT_T} nucleotide_e;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kcf_stream_if #(.payload_t(cfg_item_t))   cfg_if ();
  kcf_stream_if #(.payload_t(base_item_t))  bases_if ();
  kcf_stream_if #(.payload_t(clump_item_t)) clumps_if ();

  // Locally driven channel signals, all known from time zero.
  logic        cfg_valid  = 1'b0;
  cfg_item_t   cfg_data   = '0;
  logic        send_valid = 1'b0;
  base_item_t  send_data  = '0;
  logic        recv_ready = 1'b0;

  assign cfg_if.valid    = cfg_valid;
  assign cfg_if.data     = cfg_data;
  assign bases_if.valid  = send_valid;
  assign bases_if.data   = send_data;
  assign clumps_if.ready = recv_ready;

  kmer_clump_finder_top dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_if),
    .bases  (bases_if),
    .clumps (clumps_if)
  );

  // Stimulus and expectation stores.
  base_item_t  bases_todo [$];
  clump_item_t clumps_due [$];
  int          mismatches = 0;

  // Idling controls, changed by the stimulus only at falling edges.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req       = 1'b0;
  int unsigned hold_left      = 0;

  // Shadow configuration and sequence state of the count model.
  logic [KLEN_W-1:0]    set_klen = KMER_LENGTH_RESET;
  logic [WLEN_W-1:0]    set_wlen = WINDOW_LENGTH_RESET;
  logic [CNT_W-1:0]     set_thr  = THRESHOLD_RESET;
  logic [31:0]          roll_kmer = '0;
  int unsigned          bases_seen = 0;
  int unsigned          ring_slot = 0;
  bit [OUT_IDX_W-1:0]   start_kmer [MAX_W];
  bit                   start_live [MAX_W];
  bit [CNT_W-1:0]       kmer_tally [TABLE_SIZE];
  bit                   clumped_seen [TABLE_SIZE];

  // Clock generation.
  initial begin
    forever #2 clk = ~clk;
  end

  // Run length guard.
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Advance the count model by one base and queue any newly clumped k-mer.
  function automatic void count_base(input logic [BASE_W-1:0] nt);
    int unsigned k, w, t, slot, idx, old;
    logic [31:0] mask;
    clump_item_t found;
    k = set_klen;
    if (k < 1) k = 1;
    if (k > MAX_K) k = MAX_K;
    w = set_wlen;
    if (w < k) w = k;
    if (w > MAX_W) w = MAX_W;
    t = (set_thr == 0) ? 1 : set_thr;
    mask = (32'd1 << (2 * k)) - 1;
    roll_kmer = ((roll_kmer << 2) | nt) & mask;

    // The k-mer starting one window back leaves, at most once per start.
    if (bases_seen >= w) begin
      slot = (ring_slot + MAX_W - w) % MAX_W;
      if (start_live[slot]) begin
        old = start_kmer[slot];
        if (kmer_tally[old] > 0) kmer_tally[old] = kmer_tally[old] - 1;
        start_live[slot] = 1'b0;
      end
    end

    // The k-mer ending here enters and may become a clump.
    if (bases_seen + 1 >= k) begin
      idx = roll_kmer % TABLE_SIZE;
      slot = (ring_slot + MAX_W - (k - 1)) % MAX_W;
      start_kmer[slot] = idx[OUT_IDX_W-1:0];
      start_live[slot] = 1'b1;
      if (kmer_tally[idx] < CNT_MAX) kmer_tally[idx] = kmer_tally[idx] + 1;
      if (kmer_tally[idx] >= t && !clumped_seen[idx]) begin
        clumped_seen[idx] = 1'b1;
        found.kmer_index = idx[OUT_IDX_W-1:0];
        found.count_now = kmer_tally[idx];
        clumps_due.push_back(found);
      end
    end

    if (bases_seen < MAX_W) bases_seen = bases_seen + 1;
    ring_slot = (ring_slot + 1) % MAX_W;
  endfunction

  // Base driver: offers the next pending base unless idling this cycle.
  always @(posedge clk) begin
    if (rst) begin
      send_valid <= 1'b0;
    end else if (!send_valid || bases_if.ready) begin
      if (bases_todo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        send_data  <= bases_todo.pop_front();
        send_valid <= 1'b1;
      end else begin
        send_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here once requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // Monitor: feeds accepted bases to the model and checks each clump transaction.
  always @(posedge clk) begin : monitor
    clump_item_t got, want;
    if (rst) begin
      recv_ready <= 1'b0;
    end else begin
      if (bases_if.valid && bases_if.ready) count_base(bases_if.data.base);
      if (clumps_if.valid && clumps_if.ready) begin
        got = clumps_if.data;
        if (clumps_due.size() == 0) begin
          $error("unexpected clump: kmer_index %0d count_now %0d",
                 got.kmer_index, got.count_now);
          mismatches++;
        end else begin
          want = clumps_due.pop_front();
          if (got.kmer_index !== want.kmer_index) begin
            $error("kmer_index: expected %0d, actual %0d", want.kmer_index, got.kmer_index);
            mismatches++;
          end
          if (got.count_now !== want.count_now) begin
            $error("count_now: expected %0d, actual %0d", want.count_now, got.count_now);
            mismatches++;
          end
        end
      end
      recv_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // One register write; the shadow copy follows the accepted transaction.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_VAL_W-1:0] val);
    cfg_item_t wr;
    wr.index = idx;
    wr.value = val;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= wr;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_KMER_LENGTH:   set_klen = val[KLEN_W-1:0];
      CFG_WINDOW_LENGTH: set_wlen = val;
      CFG_THRESHOLD:     set_thr  = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_VAL_W-1:0] klen, input logic [CFG_VAL_W-1:0] wlen,
                            input logic [CFG_VAL_W-1:0] thr);
    write_reg(CFG_KMER_LENGTH, klen);
    write_reg(CFG_WINDOW_LENGTH, wlen);
    write_reg(CFG_THRESHOLD, thr);
    @(negedge clk);
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 76; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 76; end
      default:       begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  task automatic add_run(input nucleotide_e nt, input int n);
    base_item_t b;
    b.base = nt;
    repeat (n) bases_todo.push_back(b);
  endtask

  // Mostly tandem repeats of random motifs, which build clumps, plus homopolymer runs and noise.
  task automatic add_random(input int n);
    int added, len, reps;
    base_item_t b;
    base_item_t motif [$];
    added = 0;
    while (added < n) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          len = $urandom_range(1, 12);
          repeat (len) begin
            b.base = $urandom_range(0, 3);
            bases_todo.push_back(b);
          end
          added += len;
        end
        2: begin
          len = $urandom_range(2, 12);
          b.base = $urandom_range(0, 3);
          repeat (len) bases_todo.push_back(b);
          added += len;
        end
        default: begin
          len = $urandom_range(1, 9);
          reps = $urandom_range(2, 6);
          motif.delete();
          repeat (len) begin
            b.base = $urandom_range(0, 3);
            motif.push_back(b);
          end
          repeat (reps) foreach (motif[i]) bases_todo.push_back(motif[i]);
          added += len * reps;
        end
      endcase
    end
  endtask

  // Waits until every base is in and every clump out, plus the pipeline tail.
  task automatic settle();
    while (bases_todo.size() != 0 || send_valid) @(negedge clk);
    while (clumps_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    while (clumps_due.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input logic [CFG_VAL_W-1:0] klen, input logic [CFG_VAL_W-1:0] wlen,
                           input logic [CFG_VAL_W-1:0] thr, input idle_mode_e mode,
                           input int n);
    set_config(klen, wlen, thr);
    set_idle(mode);
    add_random(n);
    settle();
  endtask

  // Stimulus sequence.
  initial begin : stimulus
    string intro;
    int k;
    base_item_t b;
    intro = "AAAAAATTTTTTACGTACGTACGT";
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: homopolymer clumps, then every base in a repeated motif.
    set_idle(IDLE_NONE);
    foreach (intro[i]) begin
      case (intro[i])
        "A":     b.base = NT_A;
        "C":     b.base = NT_C;
        "G":     b.base = NT_G;
        default: b.base = NT_T;
      endcase
      bases_todo.push_back(b);
    end
    settle();

    // Longest k-mer, widest window, every new k-mer clumps; receiver holds off.
    set_config(MAX_K, MAX_W, 1);
    add_random(600);
    hold_req = 1'b1;
    @(negedge clk);
    hold_req = 1'b0;
    settle();

    // Out-of-range settings at both ends.
    run_phase(0, 0, 0, IDLE_SENDER, 40);
    run_phase(15, 1023, 1023, IDLE_RECEIVER, 60);

    // Highest reachable count: a long G run with a full window and threshold.
    set_config(1, MAX_W, MAX_W);
    set_idle(IDLE_BOTH);
    add_run(NT_G, MAX_W + 8);
    add_random(10);
    settle();

    // Upper register bits ignored for the k-mer length; window below it.
    run_phase(10'h3F3, 1, 1, IDLE_NONE, 40);
    run_phase(MAX_K, MAX_K, 2, IDLE_SENDER, 80);

    // Random settings.
    for (int p = 0; p < 8; p++) begin
      k = $urandom_range(1, MAX_K);
      run_phase(k, $urandom_range(k, 48), $urandom_range(2, 4), idle_mode_e'(p % 4), 70);
    end

    if (mismatches == 0 && clumps_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
